FILE: rtl/reprojection_residual_jacobian_core_assert.svh
// Assertion macros used by the core's back sequencer
`ifndef REPROJECTION_RESIDUAL_JACOBIAN_CORE_ASSERT_SVH
`define REPROJECTION_RESIDUAL_JACOBIAN_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define RRJ_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("rrj assertion failed");
`define RRJ_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rrj assertion failed");
`else
`define RRJ_ASSERT_IMP(lbl, ante, cons)
`define RRJ_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

FILE: rtl/rrj_pkg.sv
package rrj_pkg;

  localparam int CAM_COUNT     = 2;
  localparam int FRAC_BITS     = 16;
  localparam int WORDS_PER_CAM = 12;
  localparam int CAM_W         = (CAM_COUNT > 1) ? $clog2(CAM_COUNT) : 1;
  localparam int DIV_W         = 32 + FRAC_BITS;
  localparam int DIV_CNT_W     = $clog2(DIV_W + 1);
  localparam int Q_DEPTH       = 2;
  localparam int Q_PTR_W       = $clog2(Q_DEPTH);

  typedef logic signed [31:0] word_t;

  localparam word_t Q_ONE = word_t'(1 << FRAC_BITS);

  typedef struct packed {
    logic        kind;
    logic [3:0]  camera;
    logic [3:0]  entry;
    word_t       word_value;
    word_t       point_x;
    word_t       point_y;
    word_t       point_z;
    word_t       point_w;
    word_t       obs_u;
    word_t       obs_v;
  } in_req_t;

  typedef struct packed {
    word_t residual;
    word_t jac_point_x;
    word_t jac_point_y;
    word_t jac_point_z;
    word_t jac_rot_x;
    word_t jac_rot_y;
    word_t jac_rot_z;
    word_t jac_trans_x;
    word_t jac_trans_y;
    word_t jac_trans_z;
    logic  degenerate;
    logic  last;
  } out_req_t;

  typedef struct packed {
    logic                           cam_nz;
    logic                           degen;
    word_t [WORDS_PER_CAM-1:0]      mat;
    word_t [3:0]                    pt;
    word_t [1:0]                    obs;
  } job_t;

  function automatic word_t sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  function automatic word_t neg32(input word_t x);
    return sat32(-(64'(x)));
  endfunction

  function automatic word_t qmul_fin(input logic signed [63:0] p);
    return sat32(p >>> FRAC_BITS);
  endfunction

endpackage

FILE: rtl/rrj_div.sv
module rrj_div (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  rrj_pkg::word_t num_i,
  input  rrj_pkg::word_t den_i,
  output logic           busy_o,
  output logic           done_o,
  output rrj_pkg::word_t quo_o
);
  import rrj_pkg::*;

  logic                 busy_q, done_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [32:0]          rem_q;
  logic [DIV_W-1:0]     nsh_q, quo_q;
  logic [31:0]          den_q;
  logic                 neg_q, zero_q;
  word_t                res_q;

  logic [31:0] num_mag, den_mag;
  logic [32:0] rem_sh, rem_sub;
  logic        ge;
  word_t       fin;

  assign num_mag = num_i[31] ? (~num_i + 32'd1) : num_i;
  assign den_mag = den_i[31] ? (~den_i + 32'd1) : den_i;
  assign rem_sh  = {rem_q[31:0], nsh_q[DIV_W-1]};
  assign rem_sub = rem_sh - {1'b0, den_q};
  assign ge      = rem_sh >= {1'b0, den_q};

  always_comb begin
    if (zero_q) begin
      fin = '0;
    end else if (neg_q) begin
      if (quo_q[DIV_W-1:32] != '0 || (quo_q[31] && quo_q[30:0] != '0)) begin
        fin = 32'sh80000000;
      end else begin
        fin = word_t'(-quo_q[31:0]);
      end
    end else if (quo_q[DIV_W-1:31] != '0) begin
      fin = 32'sh7fffffff;
    end else begin
      fin = word_t'(quo_q[31:0]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= DIV_CNT_W'(DIV_W);
      end else if (busy_q) begin
        if (cnt_q != '0) begin
          cnt_q <= cnt_q - 1'b1;
        end else begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      nsh_q  <= {num_mag, {FRAC_BITS{1'b0}}};
      rem_q  <= '0;
      quo_q  <= '0;
      den_q  <= den_mag;
      neg_q  <= num_i[31] ^ den_i[31];
      zero_q <= (den_i == '0);
    end else if (busy_q && cnt_q != '0) begin
      rem_q <= ge ? rem_sub : rem_sh;
      quo_q <= {quo_q[DIV_W-2:0], ge};
      nsh_q <= {nsh_q[DIV_W-2:0], 1'b0};
    end
    if (busy_q && cnt_q == '0) begin
      res_q <= fin;
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quo_o  = res_q;

endmodule

FILE: rtl/rrj_queue.sv
module rrj_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  rrj_pkg::job_t data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output rrj_pkg::job_t data_o
);
  import rrj_pkg::*;

  job_t               mem_q [Q_DEPTH];
  logic [Q_PTR_W-1:0] wptr_q, rptr_q;
  logic [Q_PTR_W:0]   cnt_q;

  assign full_o  = cnt_q == (Q_PTR_W+1)'(Q_DEPTH);
  assign valid_o = cnt_q != '0;
  assign data_o  = mem_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= wptr_q + 1'b1;
      end
      if (pop_i) begin
        rptr_q <= rptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (!push_i && pop_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= data_i;
    end
  end

endmodule

FILE: rtl/rrj_front.sv
module rrj_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  rrj_pkg::in_req_t in_req_i,
  output logic             push_o,
  output rrj_pkg::job_t    job_o,
  input  logic             full_i
);
  import rrj_pkg::*;

  word_t [WORDS_PER_CAM-1:0] cam_mem [CAM_COUNT];
  word_t [WORDS_PER_CAM-1:0] row_q;
  word_t [3:0]               pt_q;
  word_t [1:0]               obs_q;
  logic                      cam_nz_q, degen_q;
  logic                      valid_q, valid_d;

  logic             in_fire, cam_ok, entry_ok;
  logic [CAM_W-1:0] cam_idx;

  assign in_stall_o = valid_q && full_i;
  assign in_fire    = in_valid_i && !in_stall_o;
  assign cam_ok     = 5'(in_req_i.camera) < 5'(CAM_COUNT);
  assign entry_ok   = in_req_i.entry < 4'(WORDS_PER_CAM);
  assign cam_idx    = in_req_i.camera[CAM_W-1:0];
  assign push_o     = valid_q && !full_i;
  assign valid_d    = (valid_q && full_i) || (in_fire && in_req_i.kind);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && !in_req_i.kind && cam_ok && entry_ok) begin
      cam_mem[cam_idx][in_req_i.entry] <= in_req_i.word_value;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && in_req_i.kind) begin
      row_q    <= cam_mem[cam_idx];
      pt_q     <= {in_req_i.point_w, in_req_i.point_z, in_req_i.point_y, in_req_i.point_x};
      obs_q    <= {in_req_i.obs_v, in_req_i.obs_u};
      cam_nz_q <= in_req_i.camera != '0;
      degen_q  <= !cam_ok || (in_req_i.point_w == '0);
    end
  end

  always_comb begin
    job_o        = '0;
    job_o.cam_nz = cam_nz_q;
    job_o.degen  = degen_q;
    job_o.mat    = row_q;
    job_o.pt     = pt_q;
    job_o.obs    = obs_q;
  end

endmodule

FILE: rtl/rrj_back.sv
`include "reprojection_residual_jacobian_core_assert.svh"

module rrj_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [30:0]       cfg_wdata_i,
  input  logic              job_valid_i,
  input  rrj_pkg::job_t     job_i,
  output logic              job_pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output rrj_pkg::out_req_t out_req_o
);
  import rrj_pkg::*;

  localparam logic [4:0] S_IDLE      = 5'd0;
  localparam logic [4:0] S_P_MUL     = 5'd1;
  localparam logic [4:0] S_P_ACC     = 5'd2;
  localparam logic [4:0] S_CHECK     = 5'd3;
  localparam logic [4:0] S_XN_DIV    = 5'd4;
  localparam logic [4:0] S_XN_WAIT   = 5'd5;
  localparam logic [4:0] S_S_MUL     = 5'd6;
  localparam logic [4:0] S_S_ACC     = 5'd7;
  localparam logic [4:0] S_DINV_DIV  = 5'd8;
  localparam logic [4:0] S_DINV_WAIT = 5'd9;
  localparam logic [4:0] S_PROJ_DIV  = 5'd10;
  localparam logic [4:0] S_PROJ_WAIT = 5'd11;
  localparam logic [4:0] S_T_MUL     = 5'd12;
  localparam logic [4:0] S_T_ACC     = 5'd13;
  localparam logic [4:0] S_JP_DIV    = 5'd14;
  localparam logic [4:0] S_JP_WAIT   = 5'd15;
  localparam logic [4:0] S_D2_DIV    = 5'd16;
  localparam logic [4:0] S_D2_WAIT   = 5'd17;
  localparam logic [4:0] S_R_MUL     = 5'd18;
  localparam logic [4:0] S_R_ACC     = 5'd19;
  localparam logic [4:0] S_EMIT      = 5'd20;

  logic [4:0]  state_q, state_d;
  logic [1:0]  i_q, i_d, k_q, k_d, m_q, m_d;
  logic        r_q, r_d;
  logic        out_valid_q, out_valid_d;
  logic [30:0] min_depth_q;

  word_t [WORDS_PER_CAM-1:0] mat_q;
  word_t [3:0]               pt_q;
  word_t [1:0]               obs_q;
  logic                      cam_nz_q;
  word_t                     p_q [3];
  word_t                     xn_q [3];
  word_t                     s_q [3];
  word_t                     dv_q [3];
  word_t                     dinv_q, proj_q, t_q;
  logic signed [35:0]        acc_q;
  logic signed [63:0]        prod_q;
  out_req_t                  row_q, out_q;

  logic               job_pop, out_load, div_start, div_busy, div_done, pz_degen;
  logic [3:0]         mat_idx;
  word_t              mat_rd, mul_a, mul_b, nsel, qm, div_num, div_den, div_q, pz;
  logic [31:0]        az;
  logic signed [35:0] acc_sum;

  rrj_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .busy_o  (div_busy),
    .done_o  (div_done),
    .quo_o   (div_q)
  );

  assign pz       = p_q[2];
  assign az       = pz[31] ? (~pz + 32'd1) : pz;
  assign pz_degen = (pz == '0) || (az < {1'b0, min_depth_q});
  assign qm       = qmul_fin(prod_q);
  assign acc_sum  = acc_q + 36'(qm);
  assign mat_rd   = mat_q[mat_idx];

  always_comb begin
    unique case (state_q)
      S_T_MUL: mat_idx = {2'd2, k_q};
      S_T_ACC: mat_idx = {1'b0, r_q, k_q};
      default: mat_idx = {i_q, k_q};
    endcase
  end

  always_comb begin
    unique case ({m_q, k_q})
      4'b0001: nsel = s_q[2];
      4'b0010: nsel = neg32(s_q[1]);
      4'b0100: nsel = neg32(s_q[2]);
      4'b0110: nsel = s_q[0];
      4'b1000: nsel = s_q[1];
      4'b1001: nsel = neg32(s_q[0]);
      default: nsel = '0;
    endcase
  end

  always_comb begin
    unique case (state_q)
      S_P_MUL: begin mul_a = mat_rd;   mul_b = pt_q[k_q]; end
      S_S_MUL: begin mul_a = mat_rd;   mul_b = xn_q[k_q]; end
      S_R_MUL: begin mul_a = dv_q[m_q]; mul_b = nsel;     end
      default: begin mul_a = mat_rd;   mul_b = proj_q;    end
    endcase
  end

  always_comb begin
    div_start = 1'b1;
    unique case (state_q)
      S_XN_DIV:   begin div_num = pt_q[k_q]; div_den = pt_q[3]; end
      S_DINV_DIV: begin div_num = Q_ONE;     div_den = pz;      end
      S_PROJ_DIV: begin div_num = p_q[r_q];  div_den = pz;      end
      S_JP_DIV:   begin div_num = t_q;       div_den = pz;      end
      S_D2_DIV:   begin div_num = proj_q;    div_den = pz;      end
      default: begin
        div_num   = t_q;
        div_den   = pz;
        div_start = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_d     = state_q;
    i_d         = i_q;
    k_d         = k_q;
    m_d         = m_q;
    r_d         = r_q;
    out_valid_d = out_valid_q && out_stall_i;
    job_pop     = 1'b0;
    out_load    = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (job_valid_i) begin
          job_pop = 1'b1;
          i_d     = '0;
          k_d     = '0;
          m_d     = '0;
          r_d     = 1'b0;
          state_d = job_i.degen ? S_EMIT : S_P_MUL;
        end
      end
      S_P_MUL: state_d = S_P_ACC;
      S_P_ACC: begin
        state_d = S_P_MUL;
        if (k_q == 2'd3) begin
          k_d = '0;
          if (i_q == 2'd2) begin
            state_d = S_CHECK;
          end else begin
            i_d = i_q + 2'd1;
          end
        end else begin
          k_d = k_q + 2'd1;
        end
      end
      S_CHECK: state_d = pz_degen ? S_EMIT : S_XN_DIV;
      S_XN_DIV: state_d = S_XN_WAIT;
      S_XN_WAIT: begin
        if (div_done) begin
          if (k_q == 2'd2) begin
            k_d     = '0;
            i_d     = '0;
            state_d = S_S_MUL;
          end else begin
            k_d     = k_q + 2'd1;
            state_d = S_XN_DIV;
          end
        end
      end
      S_S_MUL: state_d = S_S_ACC;
      S_S_ACC: begin
        state_d = S_S_MUL;
        if (k_q == 2'd2) begin
          k_d = '0;
          if (i_q == 2'd2) begin
            state_d = S_DINV_DIV;
          end else begin
            i_d = i_q + 2'd1;
          end
        end else begin
          k_d = k_q + 2'd1;
        end
      end
      S_DINV_DIV: state_d = S_DINV_WAIT;
      S_DINV_WAIT: begin
        if (div_done) begin
          state_d = S_PROJ_DIV;
        end
      end
      S_PROJ_DIV: state_d = S_PROJ_WAIT;
      S_PROJ_WAIT: begin
        if (div_done) begin
          k_d     = '0;
          state_d = S_T_MUL;
        end
      end
      S_T_MUL: state_d = S_T_ACC;
      S_T_ACC: state_d = S_JP_DIV;
      S_JP_DIV: state_d = S_JP_WAIT;
      S_JP_WAIT: begin
        if (div_done) begin
          if (k_q == 2'd2) begin
            k_d     = '0;
            state_d = cam_nz_q ? S_D2_DIV : S_EMIT;
          end else begin
            k_d     = k_q + 2'd1;
            state_d = S_T_MUL;
          end
        end
      end
      S_D2_DIV: state_d = S_D2_WAIT;
      S_D2_WAIT: begin
        if (div_done) begin
          k_d     = '0;
          m_d     = '0;
          state_d = S_R_MUL;
        end
      end
      S_R_MUL: state_d = S_R_ACC;
      S_R_ACC: begin
        state_d = S_R_MUL;
        if (m_q == 2'd2) begin
          m_d = '0;
          if (k_q == 2'd2) begin
            k_d     = '0;
            state_d = S_EMIT;
          end else begin
            k_d = k_q + 2'd1;
          end
        end else begin
          m_d = m_q + 2'd1;
        end
      end
      S_EMIT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          if (!r_q) begin
            r_d     = 1'b1;
            state_d = row_q.degenerate ? S_EMIT : S_PROJ_DIV;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      i_q         <= '0;
      k_q         <= '0;
      m_q         <= '0;
      r_q         <= 1'b0;
      out_valid_q <= 1'b0;
      min_depth_q <= 31'd1;
    end else begin
      state_q     <= state_d;
      i_q         <= i_d;
      k_q         <= k_d;
      m_q         <= m_d;
      r_q         <= r_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        min_depth_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    unique case (state_q)
      S_IDLE: begin
        if (job_valid_i) begin
          mat_q    <= job_i.mat;
          pt_q     <= job_i.pt;
          obs_q    <= job_i.obs;
          cam_nz_q <= job_i.cam_nz;
          row_q    <= {{($bits(out_req_t)-2){1'b0}}, job_i.degen, 1'b0};
          acc_q    <= '0;
        end
      end
      S_P_ACC: begin
        if (k_q == 2'd3) begin
          p_q[i_q] <= sat32(64'(acc_sum));
          acc_q    <= '0;
        end else begin
          acc_q <= acc_sum;
        end
      end
      S_CHECK: begin
        if (pz_degen) begin
          row_q.degenerate <= 1'b1;
        end
      end
      S_XN_WAIT: begin
        if (div_done) begin
          xn_q[k_q] <= div_q;
        end
      end
      S_S_ACC: begin
        if (k_q == 2'd2) begin
          s_q[i_q] <= sat32(64'(acc_sum));
          acc_q    <= '0;
        end else begin
          acc_q <= acc_sum;
        end
      end
      S_DINV_WAIT: begin
        if (div_done) begin
          dinv_q <= neg32(div_q);
        end
      end
      S_PROJ_WAIT: begin
        if (div_done) begin
          proj_q            <= div_q;
          row_q.residual    <= sat32(64'(obs_q[r_q]) - 64'(div_q));
          row_q.jac_rot_x   <= '0;
          row_q.jac_rot_y   <= '0;
          row_q.jac_rot_z   <= '0;
          row_q.jac_trans_x <= '0;
          row_q.jac_trans_y <= '0;
          row_q.jac_trans_z <= '0;
        end
      end
      S_T_ACC: t_q <= sat32(64'(mat_rd) - 64'(qm));
      S_JP_WAIT: begin
        if (div_done) begin
          unique case (k_q)
            2'd0:    row_q.jac_point_x <= neg32(div_q);
            2'd1:    row_q.jac_point_y <= neg32(div_q);
            default: row_q.jac_point_z <= neg32(div_q);
          endcase
        end
      end
      S_D2_WAIT: begin
        if (div_done) begin
          dv_q[0]           <= r_q ? '0 : dinv_q;
          dv_q[1]           <= r_q ? dinv_q : '0;
          dv_q[2]           <= div_q;
          row_q.jac_trans_x <= r_q ? '0 : dinv_q;
          row_q.jac_trans_y <= r_q ? dinv_q : '0;
          row_q.jac_trans_z <= div_q;
          acc_q             <= '0;
        end
      end
      S_R_ACC: begin
        if (m_q == 2'd2) begin
          unique case (k_q)
            2'd0:    row_q.jac_rot_x <= sat32(64'(acc_sum));
            2'd1:    row_q.jac_rot_y <= sat32(64'(acc_sum));
            default: row_q.jac_rot_z <= sat32(64'(acc_sum));
          endcase
          acc_q <= '0;
        end else begin
          acc_q <= acc_sum;
        end
      end
      S_EMIT: begin
        if (out_load) begin
          out_q <= {row_q[$bits(out_req_t)-1:1], r_q};
        end
      end
      default: ;
    endcase
  end

  assign job_pop_o   = job_pop;
  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_q;

  `RRJ_ASSERT_IMP(a_div_idle, div_start, !div_busy)
  `RRJ_ASSERT_IMP(a_pop_valid, job_pop, job_valid_i)
  `RRJ_ASSERT_IMP(a_degen_zero, out_valid_q && out_q.degenerate, out_q.residual == '0 && out_q.jac_point_x == '0 && out_q.jac_trans_z == '0)
  `RRJ_ASSERT_IMP(a_fixed_cam, out_load && !cam_nz_q, row_q.jac_trans_z == '0 && row_q.jac_rot_x == '0)

endmodule

FILE: rtl/reprojection_residual_jacobian_core.sv
// Load requests are accepted back to back while in_stall_o is low.
// An observation passes the front stage register and the queue, then the back sequencer runs
// 14 divisions (12 for camera 0) on one radix-2 divider, plus its multiply-accumulate steps;
// each observation yields two result rows, degenerate ones included.
// Reset (rst_ni low, asynchronous) empties the pipeline and sets min_depth to 1;
// the camera table is not cleared.
module reprojection_residual_jacobian_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [30:0]       cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  rrj_pkg::in_req_t  in_req_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output rrj_pkg::out_req_t out_req_o
);
  import rrj_pkg::*;

  logic push, full, job_valid, job_pop;
  job_t job_in, job_out;

  rrj_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_req_i   (in_req_i),
    .push_o     (push),
    .job_o      (job_in),
    .full_i     (full)
  );

  rrj_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (job_in),
    .full_o  (full),
    .pop_i   (job_pop),
    .valid_o (job_valid),
    .data_o  (job_out)
  );

  rrj_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .job_valid_i (job_valid),
    .job_i       (job_out),
    .job_pop_o   (job_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_req_o   (out_req_o)
  );

endmodule
